// ===== src/mntsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mntsr_pkg;

	// status nibbles
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CONTROL  = 4'hB;

	// sustain controller
	localparam logic [6:0] CC_SUSTAIN  = 7'd64;
	localparam logic [6:0] CC_VAL_ON   = 7'd127;
	localparam logic [6:0] CC_VAL_OFF  = 7'd0;

	localparam int unsigned NOTE_COUNT = 128;
	localparam int unsigned NOTE_W     = $clog2(NOTE_COUNT);

	// register reset values
	localparam logic [3:0] RST_OCTAVE    = 4'd0;
	localparam logic [3:0] RST_SEMITONE  = 4'd0;
	localparam logic       RST_SPLIT_EN  = 1'b0;
	localparam logic [6:0] RST_SPLIT_PT  = 7'd60;
	localparam logic [3:0] RST_UPPER_CH  = 4'd0;
	localparam logic [3:0] RST_LOWER_CH  = 4'd1;
	localparam logic [1:0] RST_MUTE      = 2'd0;
	localparam logic       RST_PASS_EN   = 1'b1;

	localparam int unsigned PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_OCTAVE    = 3'd0,
		REG_SEMITONE  = 3'd1,
		REG_SPLIT_EN  = 3'd2,
		REG_SPLIT_PT  = 3'd3,
		REG_UPPER_CH  = 3'd4,
		REG_LOWER_CH  = 3'd5,
		REG_MUTE      = 3'd6,
		REG_PASS_EN   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
		logic       held;
	} res_t;

endpackage

`default_nettype wire

// ===== src/midi_note_transpose_split_router_core.sv =====
// MIDI keyboard split and transpose router.
//
// Input channel (in_valid/in_ready): one word per MIDI message (operation=0)
// or sustain pedal toggle (operation=1). Output channel (out_valid/out_ready):
// zero, one or two words per input word, upper voice first, with last set on
// the final word of each input. An input that causes no word leaves nothing.
// Configuration goes through the APB port, one 32-bit register per 4 bytes;
// write it only while the block is idle.
//
// An accepted word is held in the input stage, and its first result is
// loaded from there into the output register once that register is free.
// A word with one result retires as that result is loaded (a word with
// none as soon as it advances), and the next word can be accepted in that
// same cycle; a word with two results holds the input stage until its
// second result is loaded, since the single output register takes one
// result per cycle while the receiver does not stall.
//
// Reset clears the pedal state, the 128-bit sounding-note store and all
// handshake state, and loads the register reset values. When the receiver
// stalls, the output register holds its word and the input stage holds its
// word; in_ready stays low while that word waits to retire.
`timescale 1ns / 1ps
`default_nettype none

module midi_note_transpose_split_router_core
	import mntsr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                operation,
	input  wire logic [7:0]          status_byte,
	input  wire logic [6:0]          data_one,
	input  wire logic [6:0]          data_two,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [7:0]          status_out,
	output logic      [6:0]          data_one_out,
	output logic      [6:0]          data_two_out,
	output logic                     note_held,
	output logic                     last
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [3:0] octave_q;
	logic [3:0] semitone_q;
	logic       split_en_q;
	logic [6:0] split_pt_q;
	logic [3:0] upper_ch_q;
	logic [3:0] lower_ch_q;
	logic [1:0] mute_q;
	logic       pass_en_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q   <= RST_OCTAVE;
			semitone_q <= RST_SEMITONE;
			split_en_q <= RST_SPLIT_EN;
			split_pt_q <= RST_SPLIT_PT;
			upper_ch_q <= RST_UPPER_CH;
			lower_ch_q <= RST_LOWER_CH;
			mute_q     <= RST_MUTE;
			pass_en_q  <= RST_PASS_EN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_OCTAVE:   octave_q   <= pwdata[3:0];
				REG_SEMITONE: semitone_q <= pwdata[3:0];
				REG_SPLIT_EN: split_en_q <= pwdata[0];
				REG_SPLIT_PT: split_pt_q <= pwdata[6:0];
				REG_UPPER_CH: upper_ch_q <= pwdata[3:0];
				REG_LOWER_CH: lower_ch_q <= pwdata[3:0];
				REG_MUTE:     mute_q     <= pwdata[1:0];
				REG_PASS_EN:  pass_en_q  <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_OCTAVE:   prdata[3:0] = octave_q;
			REG_SEMITONE: prdata[3:0] = semitone_q;
			REG_SPLIT_EN: prdata[0]   = split_en_q;
			REG_SPLIT_PT: prdata[6:0] = split_pt_q;
			REG_UPPER_CH: prdata[3:0] = upper_ch_q;
			REG_LOWER_CH: prdata[3:0] = lower_ch_q;
			REG_MUTE:     prdata[1:0] = mute_q;
			REG_PASS_EN:  prdata[0]   = pass_en_q;
			default:      prdata      = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input stage: hold one accepted word
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] status_s1;
	logic [6:0] d1_s1;
	logic [6:0] d2_s1;
	logic       second_q;   // first result of the held word already sent

	logic in_fire;
	logic advance;
	logic retire;

	assign in_ready = !valid_s1 || retire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				second_q <= 1'b0;
			end else if (advance) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= operation;
			status_s1 <= status_byte;
			d1_s1     <= data_one;
			d2_s1     <= data_two;
		end
	end

	// ---------------------------------------------------------------
	// Pedal state and sounding-note store
	// ---------------------------------------------------------------
	logic                  sustain_q;
	logic [NOTE_COUNT-1:0] sounding_q;
	logic [NOTE_COUNT-1:0] sounding_d;

	// ---------------------------------------------------------------
	// Transpose and route
	// ---------------------------------------------------------------
	logic [8:0]        oct_ext;
	logic [8:0]        semi_ext;
	logic [8:0]        note_sum;
	logic [NOTE_W-1:0] note_idx;
	logic              note_ok;
	logic              is_off;
	logic              is_on;
	logic              up_on;
	logic              lo_on;
	logic              in_up;
	logic              in_lo;
	logic              sus_next;
	logic              held_new;

	res_t res_a;
	res_t res_b;
	logic a_v;
	logic b_v;
	res_t cur;
	logic cur_last;
	logic none;

	assign oct_ext  = {{5{octave_q[3]}}, octave_q};
	assign semi_ext = {{5{semitone_q[3]}}, semitone_q};
	// note + 12*octave + semitone; the sum stays within -104..218
	assign note_sum = {2'b00, d1_s1} + (oct_ext << 3) + (oct_ext << 2) + semi_ext;
	assign note_ok  = (note_sum[8:7] == 2'b00);
	assign note_idx = note_sum[NOTE_W-1:0];

	assign is_off   = !op_s1 && (status_s1[7:4] == NIB_NOTE_OFF);
	assign is_on    = !op_s1 && (status_s1[7:4] == NIB_NOTE_ON);
	assign up_on    = !mute_q[0];
	assign lo_on    = !mute_q[1];
	// split point of zero leaves the lower voice empty
	assign in_up    = up_on && (!split_en_q || (note_idx >= split_pt_q));
	assign in_lo    = lo_on && (!split_en_q || (note_idx < split_pt_q));
	assign sus_next = !sustain_q;

	// next store contents if this word touches a note
	always_comb begin
		sounding_d           = sounding_q;
		sounding_d[note_idx] = is_on;
	end
	assign held_new = sounding_d[note_idx];

	// two candidate results: slot a for the upper voice, slot b for the lower
	always_comb begin
		res_a = '0;
		res_b = '0;
		a_v   = 1'b0;
		b_v   = 1'b0;
		priority if (op_s1) begin
			res_a = '{status: {NIB_CONTROL, upper_ch_q}, d1: CC_SUSTAIN,
				d2: (sus_next ? CC_VAL_ON : CC_VAL_OFF), held: 1'b0};
			res_b = '{status: {NIB_CONTROL, lower_ch_q}, d1: CC_SUSTAIN,
				d2: (sus_next ? CC_VAL_ON : CC_VAL_OFF), held: 1'b0};
			a_v   = up_on;
			b_v   = lo_on;
		end else if (is_off || is_on) begin
			res_a = '{status: {status_s1[7:4], upper_ch_q}, d1: note_idx, d2: d2_s1,
				held: held_new};
			res_b = '{status: {status_s1[7:4], lower_ch_q}, d1: note_idx, d2: d2_s1,
				held: held_new};
			a_v   = note_ok && (is_off ? up_on : in_up);
			b_v   = note_ok && (is_off ? lo_on : in_lo);
		end else begin
			// anything else is forwarded as is when pass-through is on, mute mask or not
			res_a = '{status: status_s1, d1: d1_s1, d2: d2_s1, held: 1'b0};
			a_v   = pass_en_q;
		end
	end

	// pick the result to send this cycle
	always_comb begin
		if (second_q) begin
			cur      = res_b;
			cur_last = 1'b1;
		end else begin
			cur      = a_v ? res_a : res_b;
			cur_last = !(a_v && b_v);
		end
	end
	assign none = !a_v && !b_v;

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic out_valid_q;
	res_t out_q;
	logic last_q;
	logic load;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign retire  = advance && (none || cur_last);
	assign load    = advance && !none;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= cur;
			last_q <= cur_last;
		end
	end

	// commit pedal and store updates once per word, when it retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q  <= 1'b0;
			sounding_q <= '0;
		end else if (retire) begin
			if (op_s1) begin
				sustain_q <= sus_next;
			end
			if ((is_on || is_off) && !none) begin
				sounding_q <= sounding_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status_out   = out_q.status;
	assign data_one_out = out_q.d1;
	assign data_two_out = out_q.d2;
	assign note_held    = out_q.held;
	assign last         = last_q;

endmodule

`default_nettype wire

// ===== src/mntsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mntsr_checker
	import mntsr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] status_out,
	input wire logic [6:0] data_one_out,
	input wire logic [6:0] data_two_out,
	input wire logic       note_held,
	input wire logic       last
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status_out) && $stable(data_one_out)
			&& $stable(data_two_out) && $stable(note_held) && $stable(last))
		else $error("stalled output word changed");

	// the second result of a word follows right after the first
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second result of a word did not follow");

	// only a note on reports the note as held
	a_held_note_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (note_held == (status_out[7:4] == NIB_NOTE_ON)))
		else $error("note_held does not match a note on word");

endmodule

bind midi_note_transpose_split_router_core mntsr_checker u_mntsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status_out   (status_out),
	.data_one_out (data_one_out),
	.data_two_out (data_two_out),
	.note_held    (note_held),
	.last         (last)
);

`default_nettype wire

// ===== bench/tb_midi_note_transpose_split_router_core.sv =====
`timescale 1ns / 1ps

module tb_midi_note_transpose_split_router_core;
	import mntsr_pkg::*;

	// operation codes of an input word
	localparam logic OP_MIDI    = 1'b0;
	localparam logic OP_SUSTAIN = 1'b1;

	localparam int CLK_HALF       = 10;
	localparam int DRAIN_TAIL     = 6;    // settling margin after the drain
	localparam int WATCHDOG_LIMIT = 4000; // quiet cycles before giving up
	localparam int LONG_HOLD      = 400;  // receiver hold-off in the pressure phase
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 53;

	typedef struct packed {
		logic       op;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
	} midi_msg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
		logic       held;
		logic       last;
	} midi_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [31:0]         pwdata  = '0;
	logic [31:0]         prdata;
	logic                pready;

	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                operation   = 1'b0;
	logic [7:0]          status_byte = '0;
	logic [6:0]          data_one    = '0;
	logic [6:0]          data_two    = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          status_out;
	logic [6:0]          data_one_out;
	logic [6:0]          data_two_out;
	logic                note_held;
	logic                last;

	midi_msg_t  pending_msgs [$];
	midi_word_t expected_words [$];
	logic [6:0] recent_keys [$];
	midi_msg_t  offered_msg;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	logic long_hold_en = 1'b0;
	int hold_count     = 0;
	int fail_count     = 0;

	// shadow of the register file and of the block state
	logic signed [3:0] cfg_octave;
	logic signed [3:0] cfg_semitone;
	logic              cfg_split_en;
	logic [6:0]        cfg_split_pt;
	logic [3:0]        cfg_upper_ch;
	logic [3:0]        cfg_lower_ch;
	logic [1:0]        cfg_mute;
	logic              cfg_pass_en;
	logic [NOTE_COUNT-1:0] held_keys;
	logic              pedal_down;

	midi_note_transpose_split_router_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.status_byte  (status_byte),
		.data_one     (data_one),
		.data_two     (data_two),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status_out   (status_out),
		.data_one_out (data_one_out),
		.data_two_out (data_two_out),
		.note_held    (note_held),
		.last         (last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Work out the words one input causes, advance the shadow state and
	// queue the words, upper voice first, with last on the final one.
	function automatic void route_message(input midi_msg_t m);
		midi_word_t w [2];
		int n;
		int key;
		logic up_on;
		logic lo_on;
		logic in_up;
		logic in_lo;
		n = 0;
		up_on = !cfg_mute[0];
		lo_on = !cfg_mute[1];
		if (m.op == OP_SUSTAIN) begin
			pedal_down = !pedal_down;
			if (up_on) begin
				w[n] = '{{NIB_CONTROL, cfg_upper_ch}, CC_SUSTAIN,
					pedal_down ? CC_VAL_ON : CC_VAL_OFF, 1'b0, 1'b0};
				n++;
			end
			if (lo_on) begin
				w[n] = '{{NIB_CONTROL, cfg_lower_ch}, CC_SUSTAIN,
					pedal_down ? CC_VAL_ON : CC_VAL_OFF, 1'b0, 1'b0};
				n++;
			end
		end else if (m.status[7:4] == NIB_NOTE_OFF || m.status[7:4] == NIB_NOTE_ON) begin
			key = int'(m.d1) + 12 * int'(cfg_octave) + int'(cfg_semitone);
			// drop anything transposed off the keyboard
			if (key >= 0 && key < int'(NOTE_COUNT)) begin
				if (m.status[7:4] == NIB_NOTE_OFF) begin
					// note off reaches every unmuted voice, whatever the split
					if (up_on) begin
						w[n] = '{{NIB_NOTE_OFF, cfg_upper_ch}, 7'(key), m.d2, 1'b0, 1'b0};
						n++;
					end
					if (lo_on) begin
						w[n] = '{{NIB_NOTE_OFF, cfg_lower_ch}, 7'(key), m.d2, 1'b0, 1'b0};
						n++;
					end
					if (n > 0)
						held_keys[key] = 1'b0;
				end else begin
					in_up = up_on && (!cfg_split_en || key >= int'(cfg_split_pt));
					in_lo = lo_on && (!cfg_split_en || key < int'(cfg_split_pt));
					if (in_up) begin
						w[n] = '{{NIB_NOTE_ON, cfg_upper_ch}, 7'(key), m.d2, 1'b1, 1'b0};
						n++;
					end
					if (in_lo) begin
						w[n] = '{{NIB_NOTE_ON, cfg_lower_ch}, 7'(key), m.d2, 1'b1, 1'b0};
						n++;
					end
					if (n > 0)
						held_keys[key] = 1'b1;
				end
			end
		end else if (cfg_pass_en) begin
			w[n] = '{m.status, m.d1, m.d2, 1'b0, 1'b0};
			n++;
		end
		for (int i = 0; i < n; i++) begin
			w[i].last = (i == n - 1);
			expected_words.push_back(w[i]);
		end
	endfunction

	function automatic void check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, expv, actv);
			fail_count++;
		end
	endfunction

	// Driver: hold the offered word until accepted, predict on acceptance,
	// then either offer the next pending word or drop in_valid.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				route_message(offered_msg);
			if (!in_valid || in_ready) begin
				if (pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_msg = pending_msgs.pop_front();
					in_valid    <= 1'b1;
					operation   <= offered_msg.op;
					status_byte <= offered_msg.status;
					data_one    <= offered_msg.d1;
					data_two    <= offered_msg.d2;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted word with the oldest expectation and
	// drive out_ready, with a long hold-off when the pressure phase asks.
	always @(posedge clk) begin
		midi_word_t exp_word;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("word with nothing expected: status_out 'h%0h data_one_out 'h%0h",
						status_out, data_one_out);
					fail_count++;
				end else begin
					exp_word = expected_words.pop_front();
					check_field("status_out", exp_word.status, status_out);
					check_field("data_one_out", exp_word.d1, data_one_out);
					check_field("data_two_out", exp_word.d2, data_two_out);
					check_field("note_held", exp_word.held, note_held);
					check_field("last", exp_word.last, last);
				end
			end
			if (!long_hold_en) begin
				hold_count <= 0;
				out_ready  <= ($urandom_range(99) >= recv_stall_pct);
			end else if (hold_count < LONG_HOLD) begin
				hold_count <= hold_count + 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: give up after a long stretch with no word moving on either side.
	initial begin : watchdog
		int quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("midi_note_transpose_split_router_core verification failed");
		$finish;
	end

	// Two-phase register write; the register takes the value at the access edge.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_OCTAVE:   cfg_octave   = value[3:0];
			REG_SEMITONE: cfg_semitone = value[3:0];
			REG_SPLIT_EN: cfg_split_en = value[0];
			REG_SPLIT_PT: cfg_split_pt = value[6:0];
			REG_UPPER_CH: cfg_upper_ch = value[3:0];
			REG_LOWER_CH: cfg_lower_ch = value[3:0];
			REG_MUTE:     cfg_mute     = value[1:0];
			REG_PASS_EN:  cfg_pass_en  = value[0];
			default: ;
		endcase
	endtask

	task automatic load_setup(input logic [3:0] oct, input logic [3:0] semi,
			input logic split_en, input logic [6:0] split_pt, input logic [3:0] up_ch,
			input logic [3:0] lo_ch, input logic [1:0] mute, input logic pass_en);
		write_reg(REG_OCTAVE, 32'(oct));
		write_reg(REG_SEMITONE, 32'(semi));
		write_reg(REG_SPLIT_EN, 32'(split_en));
		write_reg(REG_SPLIT_PT, 32'(split_pt));
		write_reg(REG_UPPER_CH, 32'(up_ch));
		write_reg(REG_LOWER_CH, 32'(lo_ch));
		write_reg(REG_MUTE, 32'(mute));
		write_reg(REG_PASS_EN, 32'(pass_en));
	endtask

	// Mostly moderate shifts so notes land on the keyboard, extremes now and then.
	task automatic random_setup();
		logic [3:0] oct;
		logic [3:0] semi;
		logic [6:0] spt;
		logic [1:0] mute;
		logic [3:0] edge_shift [4];
		logic [6:0] edge_split [4];
		edge_shift = '{4'h8, 4'h7, 4'(-5), 4'(5)};
		edge_split = '{7'd0, 7'd1, 7'd126, 7'd127};
		oct  = ($urandom_range(3) == 0) ? edge_shift[$urandom_range(3)]
			: 4'($urandom_range(4) - 2);
		semi = ($urandom_range(3) == 0) ? edge_shift[$urandom_range(3)]
			: 4'($urandom_range(10) - 5);
		spt  = ($urandom_range(3) == 0) ? edge_split[$urandom_range(3)]
			: 7'($urandom_range(90, 30));
		mute = ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : 2'd0;
		load_setup(oct, semi, 1'($urandom_range(1)), spt, 4'($urandom_range(15)),
			4'($urandom_range(15)), mute, ($urandom_range(3) != 0));
	endtask

	// Mostly well-formed note traffic, note offs often aimed at recent notes,
	// with sustain toggles and arbitrary status bytes mixed in.
	function automatic midi_msg_t random_msg();
		midi_msg_t m;
		m = '{OP_MIDI, 8'($urandom_range(255)), 7'($urandom_range(127)),
			7'($urandom_range(127))};
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				m.status = {NIB_NOTE_ON, 4'($urandom_range(15))};
				recent_keys.push_back(m.d1);
				if (recent_keys.size() > 16)
					void'(recent_keys.pop_front());
			end
			4, 5, 6: begin
				m.status = {NIB_NOTE_OFF, 4'($urandom_range(15))};
				if (recent_keys.size() != 0 && $urandom_range(1) == 1)
					m.d1 = recent_keys[$urandom_range(recent_keys.size() - 1)];
			end
			7: m.op = OP_SUSTAIN;
			default: ;
		endcase
		return m;
	endfunction

	task automatic send_msg(input logic op, input logic [7:0] st, input logic [6:0] d1,
			input logic [6:0] d2);
		pending_msgs.push_back('{op, st, d1, d2});
	endtask

	// Wait until every pending word is accepted and every expected word is out, then let the
	// pipeline settle in case the last words caused nothing.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_msgs.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	initial begin
		cfg_octave   = RST_OCTAVE;
		cfg_semitone = RST_SEMITONE;
		cfg_split_en = RST_SPLIT_EN;
		cfg_split_pt = RST_SPLIT_PT;
		cfg_upper_ch = RST_UPPER_CH;
		cfg_lower_ch = RST_LOWER_CH;
		cfg_mute     = RST_MUTE;
		cfg_pass_en  = RST_PASS_EN;
		held_keys    = '0;
		pedal_down   = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset values: both voices over the full keyboard
		send_msg(OP_MIDI, 8'h90, 7'd60, 7'd100);
		send_msg(OP_MIDI, 8'h93, 7'd0, 7'd0);      // velocity zero still a note on
		send_msg(OP_MIDI, 8'h9F, 7'd127, 7'd127);
		send_msg(OP_MIDI, 8'h80, 7'd60, 7'd64);
		send_msg(OP_MIDI, 8'h8C, 7'd5, 7'd0);      // release of a note never held
		send_msg(OP_SUSTAIN, 8'hFF, 7'd127, 7'd127);
		send_msg(OP_SUSTAIN, 8'h00, 7'd0, 7'd0);
		send_msg(OP_MIDI, 8'h00, 7'd0, 7'd0);      // data byte as status, passes through
		send_msg(OP_MIDI, 8'hFF, 7'd127, 7'd127);
		send_msg(OP_MIDI, 8'hB5, 7'd64, 7'd127);
		wait_drained();

		// big upward shift, split at 64, pass-through off
		load_setup(4'(5), 4'(5), 1'b1, 7'd64, 4'd15, 4'd0, 2'd0, 1'b0);
		send_msg(OP_MIDI, 8'h90, 7'd62, 7'd90);    // lands on the top key
		send_msg(OP_MIDI, 8'h90, 7'd63, 7'd90);    // off the top, dropped
		send_msg(OP_MIDI, 8'h80, 7'd63, 7'd10);    // off the top, dropped
		send_msg(OP_MIDI, 8'h90, 7'd0, 7'd1);
		send_msg(OP_MIDI, 8'hC3, 7'd5, 7'd0);      // swallowed with pass-through off
		send_msg(OP_MIDI, 8'h80, 7'd62, 7'd0);     // release goes to both voices
		wait_drained();

		// big downward shift, upper voice muted
		load_setup(4'(-5), 4'(-5), 1'b0, 7'd60, 4'd2, 4'd9, 2'd1, 1'b1);
		send_msg(OP_MIDI, 8'h90, 7'd64, 7'd33);    // below the bottom, dropped
		send_msg(OP_MIDI, 8'h90, 7'd65, 7'd33);
		send_msg(OP_MIDI, 8'h80, 7'd65, 7'd33);
		send_msg(OP_SUSTAIN, 8'h5A, 7'd3, 7'd4);
		send_msg(OP_MIDI, 8'hE0, 7'd1, 7'd2);      // forwarded in spite of the mute
		wait_drained();

		// shift limits of the 4-bit fields, empty lower range, both voices muted
		load_setup(4'h7, 4'h8, 1'b1, 7'd0, 4'd4, 4'd6, 2'd3, 1'b1);
		send_msg(OP_MIDI, 8'h90, 7'd10, 7'd70);
		send_msg(OP_SUSTAIN, 8'h00, 7'd0, 7'd0);   // pedal flips, nothing sent
		send_msg(OP_MIDI, 8'h80, 7'd10, 7'd70);
		wait_drained();
		write_reg(REG_MUTE, 32'd0);
		send_msg(OP_MIDI, 8'h90, 7'd10, 7'd70);    // upper voice only
		wait_drained();

		// split at the top key
		load_setup(4'd0, 4'd0, 1'b1, 7'd127, 4'd3, 4'd12, 2'd0, 1'b1);
		send_msg(OP_MIDI, 8'h90, 7'd127, 7'd50);
		send_msg(OP_MIDI, 8'h90, 7'd126, 7'd50);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_setup();
			case (p % 4)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  <= 50;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 50;
				end
				default: begin
					send_idle_pct  <= 17;
					recv_stall_pct <= 17;
				end
			endcase
			// receiver holds off while the sender keeps offering
			if (p == 4)
				long_hold_en <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_msgs.push_back(random_msg());
			wait_drained();
			long_hold_en <= 1'b0;
		end

		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("midi_note_transpose_split_router_core verification clean");
		else
			$display("midi_note_transpose_split_router_core verification failed");
		$finish;
	end

endmodule
